[hdl/kvi_pkg.sv]
// keyframe vertex interpolator package: operation and status codes, widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package kvi_pkg;
    localparam int MaxFrames = 64;
    localparam int MaxGroups = 256;

    localparam logic [1:0] OP_TIME = 2'd0;
    localparam logic [1:0] OP_OFS  = 2'd1;
    localparam logic [1:0] OP_WORD = 2'd2;
    localparam logic [1:0] OP_EVAL = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    localparam logic [2:0] CFG_DUR = 3'd0;
    localparam logic [2:0] CFG_VC  = 3'd1;
    localparam logic [2:0] CFG_FX  = 3'd2;
    localparam logic [2:0] CFG_FY  = 3'd3;
    localparam logic [2:0] CFG_FZ  = 3'd4;

    localparam int CodeDiv = 1023;
    localparam int CodeStep = 11;
endpackage
`default_nettype wire

[hdl/keyframe_vertex_interpolator_top.sv]
// keyframe vertex interpolator top level: tables in synchronous memories and
// a sequencer with a shared shift-subtract divider; depends on kvi_pkg
//
// usage: pulse i_start with the item fields while o_busy is low; the
// transaction is accepted at that edge. exactly one result follows, shown for
// one cycle with o_done high. the receiver cannot stall; none is needed.
// configuration: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data,
// written only while idle.
// a write's result follows through S_WR and S_OUT, an out of range vertex's
// through S_OUT alone; o_busy drops as o_done rises, so the next transaction
// can be accepted at the edge that takes the result.
// an evaluation runs the time modulo and the fraction division on the
// 64-step divider and a search that reads the key times in turn; each of
// the two dequantize steps is a read, a registered 32x11 product and a
// division by 1023 folded over base 1024 digits; the final rounding is a
// shift.
// reset (synchronous, active low) clears configuration to duration 1,
// vertex count 1, two frames per axis, and returns the sequencer to idle;
// the table memories are not cleared and hold garbage until written.
`timescale 1ns / 1ps
`default_nettype none
module keyframe_vertex_interpolator_top #(
    parameter int MAX_FRAMES = kvi_pkg::MaxFrames,
    parameter int MAX_GROUPS = kvi_pkg::MaxGroups
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_operation,
    input  wire logic [1:0]  i_axis,
    input  wire logic [5:0]  i_frame_index,
    input  wire logic [7:0]  i_group_index,
    input  wire logic [31:0] i_data_word,
    input  wire logic signed [31:0] i_offset_value,
    input  wire logic signed [31:0] i_scale_value,
    input  wire logic [9:0]  i_vertex_number,
    input  wire logic [31:0] i_anim_time,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_done,
    output logic signed [31:0] o_position_value,
    output logic [9:0]       o_vertex_out,
    output logic [1:0]       o_axis_out,
    output logic             o_is_evaluation,
    output logic [1:0]       o_status
);
    localparam int FW = $clog2(MAX_FRAMES);
    localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int TD = 3 * MAX_FRAMES;
    localparam int TW = $clog2(TD);
    localparam int WD = TD * MAX_GROUPS;
    localparam int WW = $clog2(WD);
    localparam int CW = FW + 1;
    localparam int ThirdRecip = 683;

    localparam logic [4:0] S_IDLE = 5'd0,  S_WR = 5'd1,   S_MOD = 5'd2,
                           S_SRCH = 5'd3,  S_SRCW = 5'd4, S_RD0 = 5'd5,
                           S_RD1 = 5'd6,   S_MUL = 5'd7,  S_DQ = 5'd8,
                           S_DQW = 5'd9,   S_FR = 5'd10,  S_FRW = 5'd11,
                           S_FIN = 5'd14,
                           S_OUT = 5'd15,  S_RDW = 5'd16, S_MODW = 5'd17,
                           S_IMM = 5'd18;

    logic [31:0] r_key_mem [TD];
    logic [31:0] r_ofs_mem [TD];
    logic [31:0] r_scl_mem [TD];
    logic [31:0] r_word_mem [WD];

    logic [31:0] r_dur;
    logic [9:0]  r_vc;
    logic [6:0]  r_fr [3];
    logic [4:0]  r_st;
    logic [1:0]  r_op, r_ax;
    logic [5:0]  r_fi;
    logic [7:0]  r_gi;
    logic [31:0] r_dat, r_ofs, r_scl, r_t;
    logic [9:0]  r_vtx;
    logic [CW-1:0] r_cf, r_nlim;
    logic        r_side;
    logic [31:0] r_t0, r_t1, r_key_q, r_ofs_q, r_scl_q, r_word_q;
    logic signed [33:0] r_v1, r_v2;
    logic signed [63:0] r_prod;
    logic [16:0] r_frac;
    logic [1:0]  r_vm3;
    logic [GW-1:0] r_vg;

    // division by 1023 folded over base 1024 digits
    logic [41:0] r_dqx;
    logic [32:0] r_dqq;
    logic        r_dqn;

    // iterative divider: 64 bit magnitude by 33 bit divisor
    logic [63:0] r_dn;
    logic [32:0] r_dd;
    logic [33:0] r_rem;
    logic [6:0]  r_dc;
    logic        r_dbusy;
    logic        dgo;
    logic [63:0] dnum;
    logic [32:0] dden;
    logic [33:0] rsh;
    logic [63:0] qout;

    // vertex split into packed word and lane
    logic [19:0] vmul;
    logic [8:0]  vq;
    logic [9:0]  vr;
    assign vmul = 20'(i_vertex_number) * 20'(ThirdRecip);
    assign vq = vmul[19:11];
    assign vr = i_vertex_number - {vq, 1'b0} - {1'b0, vq};

    assign o_busy = (r_st != S_IDLE);
    assign o_cfg_ready = (r_st == S_IDLE);

    logic [TW-1:0] waddr, kaddr;
    logic [WW-1:0] wwaddr, rwaddr;
    logic wr_ok;
    assign waddr = TW'(r_ax * MAX_FRAMES + 32'(r_fi));
    assign wwaddr = WW'(32'(waddr) * MAX_GROUPS + 32'(r_gi));
    assign wr_ok = (r_ax != 2'd3) && (32'(r_fi) < MAX_FRAMES)
                   && ((r_op != kvi_pkg::OP_WORD) || (32'(r_gi) < MAX_GROUPS));
    assign kaddr = TW'(r_ax * MAX_FRAMES + 32'(r_cf) + 32'(r_side));
    assign rwaddr = WW'(32'(kaddr) * MAX_GROUPS + 32'(r_vg));

    always_ff @(posedge i_clk) begin
        if (r_st == S_WR && wr_ok) begin
            if (r_op == kvi_pkg::OP_TIME) r_key_mem[waddr] <= r_dat;
            if (r_op == kvi_pkg::OP_OFS) begin
                r_ofs_mem[waddr] <= r_ofs;
                r_scl_mem[waddr] <= r_scl;
            end
            if (r_op == kvi_pkg::OP_WORD) r_word_mem[wwaddr] <= r_dat;
        end
        r_key_q <= r_key_mem[kaddr];
        r_ofs_q <= r_ofs_mem[kaddr];
        r_scl_q <= r_scl_mem[kaddr];
        r_word_q <= r_word_mem[rwaddr];
    end

    always_comb begin
        rsh = {r_rem[32:0], r_dn[63]};
        qout = r_dn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
        end else if (dgo) begin
            r_dbusy <= 1'b1;
            r_dn <= dnum;
            r_dd <= dden;
            r_rem <= '0;
            r_dc <= 7'd0;
        end else if (r_dbusy) begin
            if (rsh >= {1'b0, r_dd}) begin
                r_rem <= rsh - {1'b0, r_dd};
                r_dn <= {r_dn[62:0], 1'b1};
            end else begin
                r_rem <= rsh;
                r_dn <= {r_dn[62:0], 1'b0};
            end
            r_dc <= r_dc + 7'd1;
            if (r_dc == 7'd63) r_dbusy <= 1'b0;
        end
    end

    logic [63:0] pm;
    logic        pn;
    logic [31:0] tcl;
    logic [31:0] dur1;
    logic signed [34:0] diff;
    logic signed [52:0] imp;
    logic [32:0] dqa;
    logic signed [33:0] dq;
    logic [47:0] imq;
    logic signed [64:0] ims;
    logic signed [64:0] fin;
    assign pn = r_prod[63];
    assign pm = pn ? 64'(-r_prod) : 64'(r_prod);
    assign tcl = r_t[31] ? 32'd0 : r_t;
    assign dur1 = (r_dur == 32'd0) ? 32'd1 : r_dur;
    assign diff = 35'(r_v2) - 35'(r_v1);
    assign imp = diff * $signed({1'b0, r_frac});
    assign dqa = r_dqq + ((r_dqx == 42'(kvi_pkg::CodeDiv)) ? 33'd1 : 33'd0);
    assign dq = 34'($signed(r_ofs_q))
                + (r_dqn ? -$signed({1'b0, dqa}) : $signed({1'b0, dqa}));
    assign imq = 48'((pm + 64'd32768) >> 16);
    assign ims = pn ? -$signed({17'd0, imq}) : $signed({17'd0, imq});
    assign fin = 65'(r_v1) + ims;

    always_comb begin
        dgo = 1'b0;
        dnum = '0;
        dden = '0;
        case (r_st)
            S_MOD: begin
                dgo = 1'b1; dnum = {32'd0, tcl}; dden = {1'b0, dur1};
            end
            S_FR: begin
                dgo = 1'b1;
                dnum = {16'd0, ((r_t > r_t0) ? ((r_t - r_t0 > r_t1 - r_t0) ?
                        r_t1 - r_t0 : r_t - r_t0) : 32'd0), 16'd0}
                       + 64'((r_t1 - r_t0) >> 1);
                dden = {1'b0, r_t1 - r_t0};
            end
            default: ;
        endcase
    end

    logic [6:0] nsat;
    assign nsat = (r_ax == 2'd3) ? 7'd2 : r_fr[r_ax];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            o_done <= 1'b0;
            r_dur <= 32'd1;
            r_vc <= 10'd1;
            r_fr[0] <= 7'd2; r_fr[1] <= 7'd2; r_fr[2] <= 7'd2;
        end else begin
            o_done <= 1'b0;
            if (i_cfg_valid && r_st == S_IDLE) begin
                case (i_cfg_index)
                    kvi_pkg::CFG_DUR: r_dur <= i_cfg_data;
                    kvi_pkg::CFG_VC:  r_vc <= i_cfg_data[9:0];
                    kvi_pkg::CFG_FX:  r_fr[0] <= i_cfg_data[6:0];
                    kvi_pkg::CFG_FY:  r_fr[1] <= i_cfg_data[6:0];
                    kvi_pkg::CFG_FZ:  r_fr[2] <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            case (r_st)
                S_IDLE: if (i_start) begin
                    r_op <= i_operation; r_ax <= i_axis; r_fi <= i_frame_index;
                    r_gi <= i_group_index; r_dat <= i_data_word;
                    r_ofs <= i_offset_value; r_scl <= i_scale_value;
                    r_vtx <= i_vertex_number; r_t <= i_anim_time;
                    r_cf <= '0; r_side <= 1'b0;
                    r_vg <= GW'(vq);
                    r_vm3 <= vr[1:0];
                    if (i_operation != kvi_pkg::OP_EVAL || i_axis == 2'd3)
                        r_st <= S_WR;
                    else if (i_vertex_number >= r_vc
                             || 32'(vq) >= MAX_GROUPS) begin
                        o_position_value <= '0; o_vertex_out <= i_vertex_number;
                        o_axis_out <= i_axis; o_is_evaluation <= 1'b1;
                        o_status <= kvi_pkg::ST_RANGE; r_st <= S_OUT;
                    end else
                        r_st <= S_MOD;
                end
                S_WR: begin
                    o_position_value <= '0; o_vertex_out <= '0; o_axis_out <= '0;
                    o_is_evaluation <= 1'b0; o_status <= kvi_pkg::ST_OK;
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    o_done <= 1'b1; r_st <= S_IDLE;
                end
                S_MOD: begin
                    r_nlim <= (nsat < 7'd2) ? CW'(0)
                            : (32'(nsat) > MAX_FRAMES) ? CW'(MAX_FRAMES - 2)
                            : CW'(nsat - 7'd2);
                    r_st <= S_MODW;
                end
                S_MODW: if (!r_dbusy && !dgo) begin
                    r_t <= r_rem[31:0];
                    r_side <= 1'b1; r_st <= S_SRCH;
                end
                S_SRCH: r_st <= S_SRCW; // key[cf+1] read in flight
                S_SRCW: begin
                    if (r_cf < r_nlim && r_key_q < r_t) begin
                        r_cf <= r_cf + CW'(1); r_st <= S_SRCH;
                    end else begin
                        r_side <= 1'b0; r_st <= S_RD0;
                    end
                end
                S_RD0: r_st <= S_RDW;
                S_RDW: begin
                    if (r_side) r_t1 <= r_key_q; else r_t0 <= r_key_q;
                    r_st <= S_RD1;
                end
                S_RD1: begin
                    case (r_vm3)
                        2'd0: r_prod <= $signed(r_scl_q) * $signed({1'b0, r_word_q[9:0]});
                        2'd1: r_prod <= $signed(r_scl_q) *
                                        $signed({1'b0, r_word_q[kvi_pkg::CodeStep +: 10]});
                        default: r_prod <= $signed(r_scl_q) *
                                        $signed({1'b0, r_word_q[2*kvi_pkg::CodeStep +: 10]});
                    endcase
                    r_st <= S_DQ;
                end
                S_DQ: begin
                    r_dqx <= pm[41:0] + 42'(kvi_pkg::CodeDiv / 2);
                    r_dqq <= '0;
                    r_dqn <= pn;
                    r_st <= S_DQW;
                end
                S_DQW: begin
                    if (r_dqx > 42'(kvi_pkg::CodeDiv)) begin
                        r_dqq <= r_dqq + 33'(r_dqx >> 10);
                        r_dqx <= (r_dqx >> 10) + 42'(r_dqx[9:0]);
                    end else if (r_side) begin
                        r_v2 <= dq; r_st <= S_FR;
                    end else begin
                        r_v1 <= dq; r_side <= 1'b1; r_st <= S_RD0;
                    end
                end
                S_FR: begin
                    if (r_t1 <= r_t0) begin
                        o_position_value <= (r_v1 > 34'sd2147483647) ? 32'sh7fffffff
                            : (r_v1 < -34'sd2147483648) ? 32'sh80000000 : 32'(r_v1);
                        o_vertex_out <= r_vtx; o_axis_out <= r_ax;
                        o_is_evaluation <= 1'b1; o_status <= kvi_pkg::ST_ZERO;
                        r_st <= S_OUT;
                    end else
                        r_st <= S_FRW;
                end
                S_FRW: if (!r_dbusy && !dgo) begin
                    r_frac <= qout[16:0]; r_st <= S_IMM;
                end
                S_IMM: begin
                    r_prod <= 64'(imp);
                    r_st <= S_FIN;
                end
                S_FIN: begin
                    o_position_value <= (fin > 65'sd2147483647) ? 32'sh7fffffff
                        : (fin < -65'sd2147483648) ? 32'sh80000000 : 32'(fin);
                    o_vertex_out <= r_vtx; o_axis_out <= r_ax;
                    o_is_evaluation <= 1'b1; o_status <= kvi_pkg::ST_OK;
                    r_st <= S_OUT;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[hdl/kvi_checker.sv]
// port-level checker for the keyframe vertex interpolator, bound to the top
// depends on kvi_pkg
`timescale 1ns / 1ps
`default_nettype none
module kvi_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_start,
    input wire logic       o_busy,
    input wire logic       o_done,
    input wire logic       o_cfg_ready,
    input wire logic       o_is_evaluation,
    input wire logic [1:0] o_status
);
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("done while busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("accept without busy");
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("double result");
    a_status_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_is_evaluation) |-> o_status == kvi_pkg::ST_OK)
        else $error("status on write");
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready == !o_busy) else $error("cfg ready mismatch");
endmodule

bind keyframe_vertex_interpolator_top kvi_checker u_kvi_checker (.*);
`default_nettype wire
